// ===== sv/hfa_pkg.sv =====
// Package: page, usage and key codes, output slot counts and the per-beat action struct for the field accumulator.
package hfa_pkg;

  localparam logic [15:0] PAGE_KEYBOARD = 16'h0007;
  localparam logic [15:0] PAGE_CONSUMER = 16'h000c;

  localparam logic [15:0] USAGE_MOD_LOW  = 16'h00e0;
  localparam logic [15:0] USAGE_MOD_HIGH = 16'h00e7;

  localparam logic [15:0] USAGE_MUTE     = 16'h00e2;
  localparam logic [15:0] USAGE_VOL_UP   = 16'h00e9;
  localparam logic [15:0] USAGE_VOL_DOWN = 16'h00ea;

  localparam logic [7:0] KEY_MUTE     = 8'h7f;
  localparam logic [7:0] KEY_VOL_UP   = 8'h80;
  localparam logic [7:0] KEY_VOL_DOWN = 8'h81;

  localparam int KEY_SLOTS_OUT   = 6;
  localparam int MEDIA_SLOTS_OUT = 4;

  // What one parsed field does to the accumulated report.
  typedef struct packed {
    logic       set_seen_media;
    logic       set_seen_keyboard;
    logic [7:0] mod_mask;
    logic       key_append;
    logic [7:0] key_code;
    logic       media_append;
    logic [7:0] media_code;
  } hfa_action_t;

endpackage

// ===== sv/hid_keyboard_field_accumulator.sv =====
// Top level: HID keyboard field accumulator building a boot-style report.
// A report beat is registered and shows on the output in the cycle after its end-of-report beat is taken.
// Throughput: one field beat per cycle; the input stalls only while a finished report
// sits unread in the result register and another end-of-report beat waits behind it.
// Reset (rst, synchronous, active high) clears the accumulated report, empties both
// stages and sets media_enabled to 1.
module hid_keyboard_field_accumulator
  import hfa_pkg::*;
#(
  parameter int MAX_KEYS  = 6,
  parameter int MAX_MEDIA = 4
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: media_enabled
  input  logic        cfg_write,
  input  logic        cfg_data,
  // field channel
  input  logic        field_valid,
  output logic        field_stall,
  input  logic        kind,
  input  logic [15:0] field_page,
  input  logic [15:0] usage,
  input  logic signed [31:0] field_value,
  // report channel
  output logic        report_valid,
  input  logic        report_stall,
  output logic [7:0]  modifiers,
  output logic [47:0] keys,
  output logic [2:0]  key_count,
  output logic [31:0] media_list,
  output logic [2:0]  media_count,
  output logic        media_flag,
  output logic        keyboard_flag
);

  localparam int KEY_FILL_W   = $clog2(MAX_KEYS + 1);
  localparam int MEDIA_FILL_W = $clog2(MAX_MEDIA + 1);

  // Configuration register.
  logic media_enabled;

  // Input register: the field is reduced to the bits the decoder needs.
  logic        s1_valid;
  logic        s1_kind;
  logic [15:0] s1_page;
  logic [15:0] s1_usage;
  logic        s1_active;

  // Accumulated report.
  logic [7:0]              modifier_bits;
  logic [7:0]              key_slots [MAX_KEYS];
  logic [KEY_FILL_W-1:0]   key_fill;
  logic [7:0]              media_slots [MAX_MEDIA];
  logic [MEDIA_FILL_W-1:0] media_fill;
  logic                    seen_media;
  logic                    seen_keyboard;

  hfa_action_t action;
  logic        s1_free;
  logic        s1_take;
  logic        report_load;
  logic        key_room;
  logic        media_room;

  // Packed view of the accumulated report for the result register.
  logic [47:0]               keys_next;
  logic [31:0]               media_list_next;
  logic [KEY_FILL_W+2:0]     key_fill_wide;
  logic [MEDIA_FILL_W+2:0]   media_fill_wide;

  // The input stage holds only when an end-of-report beat cannot move into a
  // result register that still waits on the consumer.
  assign s1_free     = !s1_valid || !s1_kind || !report_valid || !report_stall;
  assign field_stall = !s1_free;
  assign s1_take     = s1_valid && s1_free;
  assign report_load = s1_take && s1_kind;

  assign key_room   = key_fill != KEY_FILL_W'(MAX_KEYS);
  assign media_room = media_fill != MEDIA_FILL_W'(MAX_MEDIA);

  hfa_decode u_decode (
    .media_enabled (media_enabled),
    .page          (s1_page),
    .usage         (s1_usage),
    .active        (s1_active),
    .action        (action)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      media_enabled <= 1'b1;
    end else if (cfg_write) begin
      media_enabled <= cfg_data;
    end
  end

  // Input register: advance whenever the stage is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= field_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && field_valid) begin
      s1_kind   <= kind;
      s1_page   <= field_page;
      s1_usage  <= usage;
      s1_active <= field_value != 32'sd0;
    end
  end

  // Accumulate one field per beat; an end-of-report beat drops everything.
  always_ff @(posedge clk) begin
    if (rst || report_load) begin
      modifier_bits <= '0;
      key_fill      <= '0;
      media_fill    <= '0;
      seen_media    <= 1'b0;
      seen_keyboard <= 1'b0;
      for (int i = 0; i < MAX_KEYS; i++) begin
        key_slots[i] <= '0;
      end
      for (int i = 0; i < MAX_MEDIA; i++) begin
        media_slots[i] <= '0;
      end
    end else if (s1_take) begin
      modifier_bits <= modifier_bits | action.mod_mask;
      if (action.set_seen_media) begin
        seen_media <= 1'b1;
      end
      if (action.set_seen_keyboard) begin
        seen_keyboard <= 1'b1;
      end
      // Append into the slot the fill count points at; a full list drops the key.
      if (action.key_append && key_room) begin
        key_fill <= key_fill + KEY_FILL_W'(1);
        for (int i = 0; i < MAX_KEYS; i++) begin
          if (key_fill == KEY_FILL_W'(i)) begin
            key_slots[i] <= action.key_code;
          end
        end
      end
      if (action.media_append && media_room) begin
        media_fill <= media_fill + MEDIA_FILL_W'(1);
        for (int i = 0; i < MAX_MEDIA; i++) begin
          if (media_fill == MEDIA_FILL_W'(i)) begin
            media_slots[i] <= action.media_code;
          end
        end
      end
    end
  end

  // Pack the slots; slots past the output width are cut off.
  always_comb begin
    keys_next       = '0;
    media_list_next = '0;
    for (int i = 0; i < KEY_SLOTS_OUT; i++) begin
      if (i < MAX_KEYS) begin
        keys_next[8*i +: 8] = key_slots[i];
      end
    end
    for (int i = 0; i < MEDIA_SLOTS_OUT; i++) begin
      if (i < MAX_MEDIA) begin
        media_list_next[8*i +: 8] = media_slots[i];
      end
    end
  end

  // Counts are reported modulo eight.
  assign key_fill_wide   = (KEY_FILL_W + 3)'(key_fill);
  assign media_fill_wide = (MEDIA_FILL_W + 3)'(media_fill);

  // Result register: hold while stalled, load on an end-of-report beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
    end else if (report_load) begin
      report_valid <= 1'b1;
    end else if (!report_stall) begin
      report_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (report_load) begin
      modifiers     <= modifier_bits;
      keys          <= keys_next;
      key_count     <= key_fill_wide[2:0];
      media_list    <= media_list_next;
      media_count   <= media_fill_wide[2:0];
      media_flag    <= seen_media;
      keyboard_flag <= seen_keyboard;
    end
  end

endmodule

// ===== sv/hfa_decode.sv =====
// Field decoder: classifies one parsed field into modifier, key and media actions.
module hfa_decode
  import hfa_pkg::*;
(
  input  logic        media_enabled,
  input  logic [15:0] page,
  input  logic [15:0] usage,
  input  logic        active,
  output hfa_action_t action
);

  logic       pressed;
  logic       is_mod;
  logic [7:0] media_code;

  assign pressed = active && (usage != 16'h0000);
  assign is_mod  = (usage >= USAGE_MOD_LOW) && (usage <= USAGE_MOD_HIGH);

  always_comb begin
    case (usage)
      USAGE_MUTE:     media_code = KEY_MUTE;
      USAGE_VOL_UP:   media_code = KEY_VOL_UP;
      USAGE_VOL_DOWN: media_code = KEY_VOL_DOWN;
      default:        media_code = 8'h00;
    endcase
  end

  always_comb begin
    action = '0;
    action.key_code   = usage[7:0];
    action.media_code = media_code;
    if (page == PAGE_CONSUMER) begin
      if (media_enabled) begin
        action.set_seen_media = 1'b1;
        action.media_append   = pressed && (media_code != 8'h00);
      end
    end else if (page == PAGE_KEYBOARD) begin
      action.set_seen_keyboard = media_enabled;
      if (pressed) begin
        if (is_mod) begin
          action.mod_mask = 8'b1 << usage[2:0];
        end else begin
          action.key_append = 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/hfa_checker.sv =====
// Checker: port-level properties of the field accumulator, bound to the top level.
module hfa_checker (
  input logic        clk,
  input logic        rst,
  input logic        field_stall,
  input logic        report_valid,
  input logic        report_stall,
  input logic [47:0] keys,
  input logic [31:0] media_list,
  input logic [2:0]  media_count,
  input logic        media_flag
);

  // A stalled report beat holds.
  a_report_hold: assert property (@(posedge clk) disable iff (rst)
    report_valid && report_stall |=> report_valid && $stable(keys))
    else $error("report beat dropped or changed while stalled");

  // Reset leaves no report pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !report_valid)
    else $error("report valid right after reset");

  // The field side stalls only behind a report that is waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    field_stall |-> report_valid && report_stall)
    else $error("field stall without a waiting report");

  // Media keys are only appended after a consumer field was seen.
  a_media_seen: assert property (@(posedge clk) disable iff (rst)
    report_valid && (media_count != 3'd0) |-> media_flag)
    else $error("media keys reported without consumer page");

  // Mapped media codes are never zero, so an empty list has a zero count.
  a_media_empty: assert property (@(posedge clk) disable iff (rst)
    report_valid && (media_list == 32'h0) |-> media_count == 3'd0)
    else $error("media count nonzero with empty media list");

endmodule

bind hid_keyboard_field_accumulator hfa_checker u_hfa_checker (
  .clk          (clk),
  .rst          (rst),
  .field_stall  (field_stall),
  .report_valid (report_valid),
  .report_stall (report_stall),
  .keys         (keys),
  .media_list   (media_list),
  .media_count  (media_count),
  .media_flag   (media_flag)
);
